/* src/rsrd_pkg.sv */
`timescale 1ns / 1ps
// rsrd_pkg: shared types and constants for the run-length sprite row decoder.
// No dependencies.
package rsrd_pkg;

	localparam int DEF_PALETTE_DEPTH = 256;
	localparam int DEF_MAX_WIDTH     = 4096;

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_PAL   = 2'd1;
	localparam logic [1:0] OP_FRAME = 2'd2;

	localparam logic [1:0] KIND_RUN    = 2'd0;
	localparam logic [1:0] KIND_BLANK  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_ROW  = 3'd1;
	localparam logic [2:0] ST_BAD_COL  = 3'd2;
	localparam logic [2:0] ST_DONE     = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam logic [2:0] RC_RUNS  = 3'd0;
	localparam logic [2:0] RC_BLANK = 3'd4;
	localparam logic [2:0] RC_END   = 3'd5;

	localparam logic [2:0] CC_ZPIX  = 3'd1;
	localparam logic [2:0] CC_ZAPIX = 3'd2;
	localparam logic [2:0] CC_TRANS = 3'd3;
	localparam logic [2:0] CC_PIX   = 3'd6;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_TINDEX = 2'd1;
	localparam logic [1:0] CFG_ODD    = 2'd2;

	localparam logic [23:0] GRAY         = 24'h808080;
	localparam logic [12:0] CNT13_MAX    = 13'h1FFF;
	localparam logic [13:0] CNT14_MAX    = 14'h3FFF;
	localparam logic [15:0] ROW_MAX      = 16'hFFFF;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

	typedef enum logic [1:0] {
		CSRC_ZERO,
		CSRC_PIX,
		CSRC_TRANS
	} csrc_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] row;
		logic [12:0] column;
		logic [12:0] length;
		logic [7:0]  alpha;
		logic [2:0]  status;
		csrc_t       csrc;
	} desc_t;

endpackage

/* src/rsrd_in_if.sv */
`timescale 1ns / 1ps
// rsrd_in_if: input channel of the sprite row decoder, valid/ready handshake.
// No dependencies.
interface rsrd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic [7:0] palette_index;
	logic [7:0] pal_red;
	logic [7:0] pal_green;
	logic [7:0] pal_blue;

	modport source (output valid, opcode, data_byte, palette_index, pal_red, pal_green,
		pal_blue, input ready);
	modport sink (input valid, opcode, data_byte, palette_index, pal_red, pal_green,
		pal_blue, output ready);
endinterface

/* src/rsrd_out_if.sv */
`timescale 1ns / 1ps
// rsrd_out_if: result channel of the sprite row decoder, valid/ready handshake.
// No dependencies.
interface rsrd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] row;
	logic [12:0] column;
	logic [12:0] length;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [2:0]  status;
	logic        last;

	modport source (output valid, kind, row, column, length, red, green, blue, alpha,
		status, last, input ready);
	modport sink (input valid, kind, row, column, length, red, green, blue, alpha,
		status, last, output ready);
endinterface

/* src/rle_sprite_row_decoder_core.sv */
`timescale 1ns / 1ps
// rle_sprite_row_decoder_core: run-length sprite frame decoder, top level.
// Depends on rsrd_pkg, rsrd_in_if, rsrd_out_if.

// Takes one transaction per cycle (stream byte, palette write or new frame)
// whenever the result buffer is free; a byte that yields two results holds the
// input until the second of them moves on, as the result port moves one result per
// cycle while the receiver is ready. At the edge that accepts an input, the
// parser updates its state, the results go into the stage-1 registers and both
// palette reads (pixel and transparent color) are issued to the two-port palette
// RAM, whose registered data is matched and formatted when a result moves into
// the result register. Palette entries read as gray until written; no clearing pass is needed.
module rle_sprite_row_decoder_core #(
	parameter int PALETTE_DEPTH = rsrd_pkg::DEF_PALETTE_DEPTH,
	parameter int MAX_WIDTH     = rsrd_pkg::DEF_MAX_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [12:0]      wr_data,
	rsrd_in_if.sink          stream,
	rsrd_out_if.source       result
);
	import rsrd_pkg::*;

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [13:0] MAXW = 14'(MAX_WIDTH);
	localparam logic [8:0]  DEPTH9 = 9'(PALETTE_DEPTH);

	typedef enum logic [3:0] {
		PH_ROW_LO, PH_ROW_HI, PH_COL_LO, PH_COL_HI, PH_PIX_Z,
		PH_PIX_IDX, PH_PIX_ALPHA, PH_PAD, PH_DONE, PH_ERROR
	} phase_t;

	// configuration
	logic [12:0] width_q;
	logic [7:0]  tidx_q;
	logic        sodd_q;

	// parser state
	phase_t      phase_q;
	logic [15:0] row_q;
	logic [12:0] col_q;
	logic [12:0] budget_q;
	logic [13:0] bytes_q;
	logic [2:0]  ccode_q;
	logic [12:0] remain_q;
	logic [7:0]  held_q;
	logic        parity_q;

	// palette
	logic [23:0]              pal_mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] pal_vld_q;

	// stage 1: up to two pending results plus palette read data
	desc_t       res_s1 [2];
	logic [1:0]  rem_s1;
	logic        sel_s1;
	logic [23:0] pix_data_s1, trans_data_s1;
	logic        pix_ok_s1, trans_ok_s1;

	logic        out_vld_q;

	logic        accept, move;
	logic [12:0] w;

	phase_t      ph;
	logic [15:0] row;
	logic [12:0] col;
	logic [12:0] bud;
	logic [13:0] rb;
	logic [2:0]  cc;
	logic [12:0] rem;
	logic [7:0]  held;
	logic        par;
	desc_t       res [2];
	logic [1:0]  n;
	logic [7:0]  pix_addr;

	function automatic desc_t mk(logic [1:0] kind, logic [15:0] r, logic [12:0] c,
		logic [12:0] len, logic [7:0] a, logic [2:0] st, csrc_t src);
		desc_t d;
		d.kind   = kind;
		d.row    = r;
		d.column = c;
		d.length = len;
		d.alpha  = a;
		d.status = st;
		d.csrc   = src;
		return d;
	endfunction

	assign w = ({1'b0, width_q} > MAXW) ? MAXW[12:0] : width_q;
	assign pix_addr = (phase_q == PH_PIX_ALPHA) ? held_q : stream.data_byte;

	assign move = (rem_s1 != 2'd0) && (!out_vld_q || result.ready);
	assign stream.ready = (rem_s1 == 2'd0) || (move && rem_s1 == 2'd1);
	assign accept = stream.valid && stream.ready;

	always_comb begin
		logic [15:0] hdr;
		logic [12:0] cnt;
		logic [12:0] len;
		logic [16:0] rsum;
		logic [13:0] csum;
		logic        do_pix, do_cmd, do_chk;
		logic [7:0]  alpha;
		ph = phase_q;
		row = row_q;
		col = col_q;
		bud = budget_q;
		rb = bytes_q;
		cc = ccode_q;
		rem = remain_q;
		held = held_q;
		par = parity_q;
		res[0] = '0;
		res[1] = '0;
		n = 2'd0;
		hdr = {stream.data_byte, held_q};
		cnt = hdr[12:0];
		len = '0;
		rsum = '0;
		csum = '0;
		do_pix = 1'b0;
		do_cmd = 1'b0;
		do_chk = 1'b0;
		alpha = ALPHA_OPAQUE;
		case (stream.opcode)
			OP_BYTE: begin
				par = ~par;
				if (ph >= PH_COL_LO && ph <= PH_PAD && rb != CNT14_MAX) rb = rb + 14'd1;
				case (ph)
					PH_ROW_LO: begin
						held = stream.data_byte;
						ph = PH_ROW_HI;
					end
					PH_ROW_HI: begin
						col = '0;
						rb = 14'd2;
						case (hdr[15:13])
							RC_RUNS: begin
								bud = cnt;
								do_chk = 1'b1;
							end
							RC_BLANK: begin
								res[n[0]] = mk(KIND_BLANK, row, '0, cnt, '0, ST_OK, CSRC_TRANS);
								n = n + 2'd1;
								rsum = {1'b0, row} + {4'd0, cnt};
								row = rsum[16] ? ROW_MAX : rsum[15:0];
								ph = PH_ROW_LO;
							end
							RC_END: begin
								res[n[0]] = mk(KIND_STATUS, row, col, '0, '0, ST_DONE, CSRC_ZERO);
								n = n + 2'd1;
								ph = PH_DONE;
							end
							default: begin
								res[n[0]] = mk(KIND_STATUS, row, col, '0, '0, ST_BAD_ROW,
									CSRC_ZERO);
								n = n + 2'd1;
								ph = PH_ERROR;
							end
						endcase
					end
					PH_COL_LO: begin
						held = stream.data_byte;
						ph = PH_COL_HI;
					end
					PH_COL_HI: begin
						cc = hdr[15:13];
						rem = cnt;
						case (cc)
							CC_ZPIX, CC_ZAPIX, CC_PIX: begin
								if (cnt == '0) do_cmd = 1'b1;
								else ph = (cc == CC_PIX) ? PH_PIX_IDX : PH_PIX_Z;
							end
							CC_TRANS: begin
								if (cnt != '0) begin
									if (col >= w) begin
										res[n[0]] = mk(KIND_STATUS, row, col, '0, '0, ST_OVERFLOW,
											CSRC_ZERO);
									end else begin
										len = w - col;
										if (cnt <= len)
											res[n[0]] = mk(KIND_RUN, row, col, cnt, '0, ST_OK,
												CSRC_TRANS);
										else
											res[n[0]] = mk(KIND_RUN, row, col, len, '0, ST_OVERFLOW,
												CSRC_TRANS);
									end
									n = n + 2'd1;
									csum = {1'b0, col} + {1'b0, cnt};
									col = csum[13] ? CNT13_MAX : csum[12:0];
								end
								rem = '0;
								do_cmd = 1'b1;
							end
							default: begin
								res[n[0]] = mk(KIND_STATUS, row, col, '0, '0, ST_BAD_COL,
									CSRC_ZERO);
								n = n + 2'd1;
								ph = PH_ERROR;
							end
						endcase
					end
					PH_PIX_Z: ph = PH_PIX_IDX;
					PH_PIX_IDX: begin
						if (cc == CC_ZAPIX) begin
							held = stream.data_byte;
							ph = PH_PIX_ALPHA;
						end else begin
							do_pix = 1'b1;
						end
					end
					PH_PIX_ALPHA: begin
						alpha = stream.data_byte;
						do_pix = 1'b1;
					end
					PH_PAD: do_chk = 1'b1;
					default: ;
				endcase
				if (do_pix) begin
					if (col < w)
						res[n[0]] = mk(KIND_RUN, row, col, 13'd1, alpha, ST_OK, CSRC_PIX);
					else
						res[n[0]] = mk(KIND_STATUS, row, col, '0, '0, ST_OVERFLOW, CSRC_ZERO);
					n = n + 2'd1;
					if (col != CNT13_MAX) col = col + 13'd1;
					rem = rem - 13'd1;
					if (rem == '0) do_cmd = 1'b1;
					else ph = (cc == CC_PIX) ? PH_PIX_IDX : PH_PIX_Z;
				end
				if (do_cmd) begin
					if ((cc == CC_ZAPIX || cc == CC_PIX) && par) ph = PH_PAD;
					else do_chk = 1'b1;
				end
				if (do_chk) begin
					if (rb < {1'b0, bud}) begin
						ph = PH_COL_LO;
					end else begin
						if (col < w) begin
							res[n[0]] = mk(KIND_RUN, row, col, w - col, '0, ST_OK, CSRC_TRANS);
							n = n + 2'd1;
						end
						if (row != ROW_MAX) row = row + 16'd1;
						col = '0;
						ph = PH_ROW_LO;
					end
				end
			end
			OP_FRAME: begin
				ph = PH_ROW_LO;
				row = '0;
				col = '0;
				bud = '0;
				rb = '0;
				cc = '0;
				rem = '0;
				held = '0;
				par = sodd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd1;
			tidx_q <= '0;
			sodd_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_WIDTH:  width_q <= wr_data;
				CFG_TINDEX: tidx_q <= wr_data[7:0];
				CFG_ODD:    sodd_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ROW_LO;
			row_q <= '0;
			col_q <= '0;
			budget_q <= '0;
			bytes_q <= '0;
			ccode_q <= '0;
			remain_q <= '0;
			held_q <= '0;
			parity_q <= 1'b0;
		end else if (accept) begin
			phase_q <= ph;
			row_q <= row;
			col_q <= col;
			budget_q <= bud;
			bytes_q <= rb;
			ccode_q <= cc;
			remain_q <= rem;
			held_q <= held;
			parity_q <= par;
		end
	end

	// palette RAM, two read ports, registered read data
	always_ff @(posedge clk) begin
		if (accept && stream.opcode == OP_PAL && {1'b0, stream.palette_index} < DEPTH9)
			pal_mem[stream.palette_index[AW-1:0]] <=
				{stream.pal_red, stream.pal_green, stream.pal_blue};
		if (accept) begin
			pix_data_s1 <= pal_mem[pix_addr[AW-1:0]];
			trans_data_s1 <= pal_mem[tidx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
			pix_ok_s1 <= 1'b0;
			trans_ok_s1 <= 1'b0;
		end else if (accept) begin
			if (stream.opcode == OP_PAL && {1'b0, stream.palette_index} < DEPTH9)
				pal_vld_q[stream.palette_index[AW-1:0]] <= 1'b1;
			pix_ok_s1 <= ({1'b0, pix_addr} < DEPTH9) && pal_vld_q[pix_addr[AW-1:0]];
			trans_ok_s1 <= ({1'b0, tidx_q} < DEPTH9) && pal_vld_q[tidx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s1 <= '0;
			sel_s1 <= 1'b0;
		end else if (accept) begin
			rem_s1 <= n;
			sel_s1 <= 1'b0;
		end else if (move) begin
			rem_s1 <= rem_s1 - 2'd1;
			sel_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1[0] <= res[0];
			res_s1[1] <= res[1];
		end
	end

	// result formatting
	desc_t       cur;
	logic [23:0] pix_rgb, trans_rgb, rgb;
	logic [7:0]  alpha_o;

	always_comb begin
		cur = res_s1[sel_s1];
		pix_rgb = pix_ok_s1 ? pix_data_s1 : GRAY;
		trans_rgb = trans_ok_s1 ? trans_data_s1 : GRAY;
		alpha_o = cur.alpha;
		case (cur.csrc)
			CSRC_PIX: begin
				rgb = pix_rgb;
				if (pix_rgb == trans_rgb) alpha_o = '0;
			end
			CSRC_TRANS: rgb = trans_rgb;
			default: rgb = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (move) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			result.kind <= cur.kind;
			result.row <= cur.row;
			result.column <= cur.column;
			result.length <= cur.length;
			result.red <= rgb[23:16];
			result.green <= rgb[15:8];
			result.blue <= rgb[7:0];
			result.alpha <= alpha_o;
			result.status <= cur.status;
			result.last <= (rem_s1 == 2'd1);
		end
	end

	assign result.valid = out_vld_q;

endmodule

/* bench/rle_sprite_row_decoder_core_test.sv */
`timescale 1ns / 1ps
// rle_sprite_row_decoder_core_test: self-checking bench for the sprite row decoder.
// Depends on rsrd_pkg, rsrd_in_if, rsrd_out_if and rle_sprite_row_decoder_core.

class run_scoreboard;
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] row;
		logic [12:0] column;
		logic [12:0] length;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [2:0]  status;
		logic        last;
	} run_t;

	typedef enum int {
		P_ROW_LO, P_ROW_HI, P_COL_LO, P_COL_HI, P_PIX_Z, P_PIX_IDX, P_PIX_ALPHA,
		P_PAD, P_DONE, P_ERROR
	} parse_t;

	run_t        pending_runs[$];
	int          errors;
	logic [12:0] width_reg;
	logic [7:0]  tindex_reg;
	logic        odd_reg;
	logic [23:0] colors[256];
	parse_t      ph;
	int          row_cnt, col_cnt, budget, bytes_rd, col_code, remaining, held, parity;
	run_t        fresh[$];

	function new();
		errors = 0;
		width_reg = 1;
		tindex_reg = 0;
		odd_reg = 0;
		foreach (colors[i]) colors[i] = rsrd_pkg::GRAY;
		start_frame();
	endfunction

	function void start_frame();
		ph = P_ROW_LO;
		row_cnt = 0; col_cnt = 0; budget = 0; bytes_rd = 0;
		col_code = 0; remaining = 0; held = 0;
		parity = odd_reg;
	endfunction

	function void set_reg(logic [1:0] idx, logic [12:0] val);
		case (idx)
			rsrd_pkg::CFG_WIDTH: width_reg = val;
			rsrd_pkg::CFG_TINDEX: tindex_reg = val[7:0];
			rsrd_pkg::CFG_ODD: odd_reg = val[0];
			default: ;
		endcase
	endfunction

	function int eff_w();
		return (width_reg > 4096) ? 4096 : int'(width_reg);
	endfunction

	function void push(logic [1:0] k, int col, int len, logic [23:0] rgb, int a, logic [2:0] st);
		run_t r;
		if (fresh.size() >= 2) return;
		r.kind = k; r.row = 16'(row_cnt); r.column = 13'(col); r.length = 13'(len);
		r.red = rgb[23:16]; r.green = rgb[15:8]; r.blue = rgb[7:0];
		r.alpha = 8'(a); r.status = st; r.last = 0;
		fresh.push_back(r);
	endfunction

	function void col_add(int n);
		col_cnt = (col_cnt + n > 8191) ? 8191 : col_cnt + n;
	endfunction

	function void end_row();
		if (col_cnt < eff_w())
			push(rsrd_pkg::KIND_RUN, col_cnt, eff_w() - col_cnt, colors[tindex_reg], 0,
				rsrd_pkg::ST_OK);
		if (row_cnt < 65535) row_cnt++;
		col_cnt = 0;
		ph = P_ROW_LO;
	endfunction

	function void row_check();
		if (bytes_rd < budget) ph = P_COL_LO;
		else end_row();
	endfunction

	function void cmd_done();
		if ((col_code == rsrd_pkg::CC_ZAPIX || col_code == rsrd_pkg::CC_PIX) && parity)
			ph = P_PAD;
		else
			row_check();
	endfunction

	function void next_pixel();
		ph = (col_code == rsrd_pkg::CC_PIX) ? P_PIX_IDX : P_PIX_Z;
	endfunction

	function void put_pixel(int idx, int a);
		logic [23:0] rgb;
		rgb = colors[idx];
		if (col_cnt < eff_w())
			push(rsrd_pkg::KIND_RUN, col_cnt, 1, rgb, (rgb == colors[tindex_reg]) ? 0 : a,
				rsrd_pkg::ST_OK);
		else
			push(rsrd_pkg::KIND_STATUS, col_cnt, 0, 0, 0, rsrd_pkg::ST_OVERFLOW);
		col_add(1);
		remaining = (remaining - 1) & 13'h1FFF;
		if (remaining == 0) cmd_done();
		else next_pixel();
	endfunction

	function void row_header(int hdr);
		int code, count;
		code = (hdr >> 13) & 7;
		count = hdr & 13'h1FFF;
		col_cnt = 0;
		bytes_rd = 2;
		case (code)
			rsrd_pkg::RC_RUNS: begin
				budget = count;
				row_check();
			end
			rsrd_pkg::RC_BLANK: begin
				push(rsrd_pkg::KIND_BLANK, 0, count, colors[tindex_reg], 0, rsrd_pkg::ST_OK);
				row_cnt = (row_cnt + count > 65535) ? 65535 : row_cnt + count;
				ph = P_ROW_LO;
			end
			rsrd_pkg::RC_END: begin
				push(rsrd_pkg::KIND_STATUS, col_cnt, 0, 0, 0, rsrd_pkg::ST_DONE);
				ph = P_DONE;
			end
			default: begin
				push(rsrd_pkg::KIND_STATUS, col_cnt, 0, 0, 0, rsrd_pkg::ST_BAD_ROW);
				ph = P_ERROR;
			end
		endcase
	endfunction

	function void col_header(int hdr);
		int count;
		count = hdr & 13'h1FFF;
		col_code = (hdr >> 13) & 7;
		remaining = count;
		case (col_code)
			rsrd_pkg::CC_ZPIX, rsrd_pkg::CC_ZAPIX, rsrd_pkg::CC_PIX: begin
				if (remaining == 0) cmd_done();
				else next_pixel();
			end
			rsrd_pkg::CC_TRANS: begin
				if (count != 0) begin
					if (col_cnt >= eff_w())
						push(rsrd_pkg::KIND_STATUS, col_cnt, 0, 0, 0, rsrd_pkg::ST_OVERFLOW);
					else if (count <= eff_w() - col_cnt)
						push(rsrd_pkg::KIND_RUN, col_cnt, count, colors[tindex_reg], 0,
							rsrd_pkg::ST_OK);
					else
						push(rsrd_pkg::KIND_RUN, col_cnt, eff_w() - col_cnt, colors[tindex_reg],
							0, rsrd_pkg::ST_OVERFLOW);
					col_add(count);
				end
				remaining = 0;
				cmd_done();
			end
			default: begin
				push(rsrd_pkg::KIND_STATUS, col_cnt, 0, 0, 0, rsrd_pkg::ST_BAD_COL);
				ph = P_ERROR;
			end
		endcase
	endfunction

	function void stream_byte(int b);
		parity ^= 1;
		if (ph >= P_COL_LO && ph <= P_PAD && bytes_rd < 16383) bytes_rd++;
		case (ph)
			P_ROW_LO: begin held = b; ph = P_ROW_HI; end
			P_ROW_HI: row_header(held | (b << 8));
			P_COL_LO: begin held = b; ph = P_COL_HI; end
			P_COL_HI: col_header(held | (b << 8));
			P_PIX_Z: ph = P_PIX_IDX;
			P_PIX_IDX: begin
				if (col_code == rsrd_pkg::CC_ZAPIX) begin
					held = b;
					ph = P_PIX_ALPHA;
				end else begin
					put_pixel(b, 255);
				end
			end
			P_PIX_ALPHA: put_pixel(held, b);
			P_PAD: row_check();
			default: ;
		endcase
	endfunction

	function void note_input(logic [1:0] op, logic [7:0] b, logic [7:0] pi,
		logic [7:0] r, logic [7:0] g, logic [7:0] bl);
		fresh.delete();
		case (op)
			rsrd_pkg::OP_BYTE: stream_byte(b);
			rsrd_pkg::OP_PAL: colors[pi] = {r, g, bl};
			rsrd_pkg::OP_FRAME: start_frame();
			default: ;
		endcase
		if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1;
		foreach (fresh[i]) pending_runs.push_back(fresh[i]);
	endfunction

	function void check_result(run_t got);
		run_t exp_run;
		if (pending_runs.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %h", got);
			return;
		end
		exp_run = pending_runs.pop_front();
		if (got !== exp_run) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected %h got %h (kind row col len r g b a st last)",
					exp_run, got);
		end
	endfunction
endclass

module rle_sprite_row_decoder_core_test;
	import rsrd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [12:0] wr_data;
	int          idle_cycles;
	int          items_sent;
	bit          timed_out;
	run_scoreboard board;

	rsrd_in_if  stream ();
	rsrd_out_if result ();

	rle_sprite_row_decoder_core dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .stream(stream.sink), .result(result.source)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_WIDTH;
		wr_data = '0;
		stream.valid = 1'b0;
		stream.opcode = OP_BYTE;
		stream.data_byte = '0;
		stream.palette_index = '0;
		stream.pal_red = '0;
		stream.pal_green = '0;
		stream.pal_blue = '0;
		board = new();
	end

	// receiver stall pattern, plus pauses-free stretches
	always @(posedge clk) begin
		int ph;
		ph = int'(($time / 20) % 600);
		if (ph < 150) result.ready <= 1'b1;
		else if (ph < 300) result.ready <= ($urandom_range(0, 3) != 0);
		else result.ready <= ($urandom_range(0, 1) != 0);
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			board.check_result({result.kind, result.row, result.column, result.length,
				result.red, result.green, result.blue, result.alpha, result.status,
				result.last});
	end

	always @(posedge clk) begin
		if (!arst_n || (stream.valid && stream.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		board.set_reg(idx, val);
	endtask

	task automatic drain();
		while (board.pending_runs.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// one transaction; valid stays high across back-to-back sends
	task automatic send(logic [1:0] op, logic [7:0] b, logic [7:0] pi = 0,
		logic [23:0] rgb = 0);
		stream.valid <= 1'b1;
		stream.opcode <= op;
		stream.data_byte <= b;
		stream.palette_index <= pi;
		stream.pal_red <= rgb[23:16];
		stream.pal_green <= rgb[15:8];
		stream.pal_blue <= rgb[7:0];
		do @(posedge clk); while (!stream.ready);
		board.note_input(op, b, pi, rgb[23:16], rgb[15:8], rgb[7:0]);
		items_sent++;
	endtask

	task automatic gap(int n);
		if (n > 0) begin
			stream.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_word(int w);
		send(OP_BYTE, w[7:0]);
		send(OP_BYTE, w[15:8]);
	endtask

	task automatic paced(logic [1:0] op, logic [7:0] b, logic [7:0] pi = 0,
		logic [23:0] rgb = 0);
		send(op, b, pi, rgb);
		if ($urandom_range(0, 7) == 0) gap($urandom_range(1, 6));
	endtask

	task automatic rand_frame();
		int rows, cmds, cc, cnt, nb;
		paced(OP_FRAME, 0);
		rows = $urandom_range(1, 4);
		for (int r = 0; r < rows; r++) begin
			case ($urandom_range(0, 9))
				0: begin
					send_word({3'(RC_BLANK), 13'($urandom_range(0, 20))});
					continue;
				end
				1: begin
					send_word({3'($urandom_range(0, 7)), 13'($urandom)});
					continue;
				end
				default: ;
			endcase
			cmds = $urandom_range(0, 3);
			nb = $urandom_range(2, 40);
			paced(OP_BYTE, nb[7:0]);
			paced(OP_BYTE, {3'(RC_RUNS), 5'(nb >> 8)});
			for (int c = 0; c < cmds; c++) begin
				case ($urandom_range(0, 9))
					0, 1: cc = CC_ZPIX;
					2, 3: cc = CC_ZAPIX;
					4, 5: cc = CC_TRANS;
					9: cc = $urandom_range(0, 7);
					default: cc = CC_PIX;
				endcase
				cnt = (cc == CC_TRANS) ? $urandom_range(0, 40) : $urandom_range(0, 4);
				if ($urandom_range(0, 30) == 0) cnt = $urandom_range(0, 8191);
				paced(OP_BYTE, cnt[7:0]);
				paced(OP_BYTE, {cc[2:0], 5'(cnt >> 8)});
				if (cc == CC_ZPIX || cc == CC_ZAPIX || cc == CC_PIX) begin
					if (cnt > 8) cnt = 8;
					for (int p = 0; p < cnt * (cc == CC_ZAPIX ? 3 : cc == CC_ZPIX ? 2 : 1);
						p++)
						paced(OP_BYTE, 8'($urandom_range(0, 15) == 0 ? $urandom :
							$urandom_range(0, 7)));
				end
			end
			if ($urandom_range(0, 3) == 0) paced(OP_BYTE, 8'($urandom));
		end
		if ($urandom_range(0, 2) != 0) send_word({3'(RC_END), 13'($urandom)});
		if ($urandom_range(0, 4) == 0) paced(OP_BYTE, 8'($urandom));
		if ($urandom_range(0, 5) == 0)
			paced(OP_PAL, 0, 8'($urandom_range(0, 7)), 24'($urandom));
		if ($urandom_range(0, 9) == 0) paced(2'd3, 8'($urandom));
	endtask

	initial begin
		items_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every code, overflow, padding
		write_reg(CFG_WIDTH, 13'd4);
		write_reg(CFG_TINDEX, 13'd255);
		write_reg(CFG_ODD, 13'd1);
		send(OP_PAL, 0, 8'd0, 24'hFFFFFF);
		send(OP_PAL, 0, 8'd255, 24'h000000);
		send(OP_PAL, 0, 8'd1, 24'h000000);
		send(OP_FRAME, 0);
		send_word({3'(RC_RUNS), 13'd30});
		send_word({3'(CC_PIX), 13'd1});
		send(OP_BYTE, 8'd1);
		send(OP_BYTE, 8'hAA);
		send_word({3'(CC_ZAPIX), 13'd1});
		send(OP_BYTE, 8'd0);
		send(OP_BYTE, 8'd0);
		send(OP_BYTE, 8'h7F);
		send_word({3'(CC_TRANS), 13'd8191});
		send_word({3'(CC_ZPIX), 13'd1});
		send(OP_BYTE, 8'd0);
		send(OP_BYTE, 8'd0);
		send_word({3'(RC_BLANK), 13'd0});
		send_word({3'(RC_BLANK), 13'h1FFF});
		send_word({3'(CC_TRANS), 13'd0});
		send(OP_FRAME, 0);
		send_word(16'hFFFF);
		gap(1);
		drain();

		write_reg(CFG_WIDTH, 13'h1FFF);
		write_reg(CFG_ODD, 13'd0);
		send(OP_FRAME, 0);
		send_word({3'(RC_RUNS), 13'd4});
		send_word({3'(RC_RUNS), 13'd6});
		send_word(16'h0000);
		send_word({3'(RC_END), 13'd0});
		send(OP_BYTE, 8'h55);
		gap(1);
		drain();

		for (int phase_no = 0; phase_no < 4; phase_no++) begin
			write_reg(CFG_WIDTH, phase_no == 0 ? 13'd1 : 13'($urandom_range(1, 48)));
			write_reg(CFG_TINDEX, 13'($urandom_range(0, 7)));
			write_reg(CFG_ODD, 13'(phase_no & 1));
			for (int i = 0; i < 8; i++)
				paced(OP_PAL, 0, (i == 7) ? 8'($urandom) : 8'(i),
					(i == 3) ? 24'hFFFFFF : 24'($urandom));
			while (items_sent < 190 * (phase_no + 1)) begin
				rand_frame();
				if ($urandom_range(0, 3) == 0) gap($urandom_range(1, 12));
			end
			gap(1);
			drain();
		end

		stream.valid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending_runs.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

/* files.f */
src/rsrd_pkg.sv
src/rsrd_in_if.sv
src/rsrd_out_if.sv
src/rle_sprite_row_decoder_core.sv
bench/rle_sprite_row_decoder_core_test.sv
